/* sv/gam_pkg.sv */
package gam_pkg;

    localparam int PIX_W          = 8;
    localparam int DIM_W          = 12;
    localparam int CFG_INDEX_W    = 1;
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int RESET_WIDTH    = 640;
    localparam int RESET_HEIGHT   = 480;
    localparam int MIN_DIM        = 3;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [PIX_W-1:0] SAT_LIMIT = 8'hff;

    typedef logic [PIX_W-1:0] pix_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // one queued job: operands of one pixel and what the back end must emit for it
    typedef struct packed {
        pix_t up;
        pix_t pix;
        pix_t left;
        pix_t right;
        logic interior;
        logic two_beats;
        logic frame_end;
    } job_t;

endpackage

/* sv/gam_ram.sv */
module gam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/gam_front.sv */
module gam_front #(
    parameter int MAX_WIDTH  = gam_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gam_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [gam_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [gam_pkg::DIM_W-1:0]        cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [gam_pkg::PIX_W-1:0]        s_tdata,
    input  logic                             queue_ready,
    output logic                             job_valid,
    output gam_pkg::job_t                    job
);

    import gam_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
    localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
    localparam int PAIR_W = 2 * PIX_W;
    localparam int RST_W  = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
    localparam int RST_H  = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

    logic [WDIM_W-1:0] width_reg, width_next;
    logic [HDIM_W-1:0] height_reg, height_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    pix_t              left_reg, left_next;
    logic [PAIR_W-1:0] cur_reg, col0_reg, col1_reg;

    logic [WDIM_W-1:0] clamp_w;
    logic [HDIM_W-1:0] clamp_h;
    logic              restart;
    logic              accept, first_col, last_col, first_row, second_row, last_row;
    logic [PAIR_W-1:0] pair, ram_q;
    logic [COL_W-1:0]  raddr;
    pix_t              up, mid, right;

    assign s_tready = queue_ready;
    assign accept   = s_tvalid && queue_ready;

    always_comb begin
        if (int'(cfg_wdata) < MIN_DIM) begin
            clamp_w = WDIM_W'(MIN_DIM);
        end else if (int'(cfg_wdata) > MAX_WIDTH) begin
            clamp_w = WDIM_W'(MAX_WIDTH);
        end else begin
            clamp_w = WDIM_W'(cfg_wdata);
        end
        if (int'(cfg_wdata) < MIN_DIM) begin
            clamp_h = HDIM_W'(MIN_DIM);
        end else if (int'(cfg_wdata) > MAX_HEIGHT) begin
            clamp_h = HDIM_W'(MAX_HEIGHT);
        end else begin
            clamp_h = HDIM_W'(cfg_wdata);
        end
    end

    assign first_col  = (col_reg == '0);
    assign last_col   = ((WDIM_W'(col_reg) + WDIM_W'(1)) == width_reg);
    assign first_row  = (row_reg == '0);
    assign second_row = (row_reg == ROW_W'(1));
    assign last_row   = ((HDIM_W'(row_reg) + HDIM_W'(1)) == height_reg);

    // columns 0 and 1 come from local copies so that a new row starts without a read
    assign pair  = first_col ? col0_reg : cur_reg;
    assign up    = pair[PAIR_W-1:PIX_W];
    assign mid   = pair[PIX_W-1:0];
    assign right = first_col ? col1_reg[PIX_W-1:0] : ram_q[PIX_W-1:0];

    // prefetch two columns ahead
    assign raddr = (int'(col_reg) + 2 >= MAX_WIDTH) ? '0 : COL_W'(int'(col_reg) + 2);

    gam_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (MAX_WIDTH)
    ) u_rows (
        .aclk  (aclk),
        .we    (accept),
        .waddr (col_reg),
        .wdata ({mid, s_tdata}),
        .re    (accept),
        .raddr (raddr),
        .rdata (ram_q)
    );

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        left_next   = left_reg;
        restart     = 1'b0;
        if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH: begin
                    width_next = clamp_w;
                    restart    = 1'b1;
                end
                REG_IMAGE_HEIGHT: begin
                    height_next = clamp_h;
                    restart     = 1'b1;
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end
        if (restart) begin
            col_next  = '0;
            row_next  = '0;
            left_next = '0;
        end else if (accept) begin
            if (last_col) begin
                col_next  = '0;
                left_next = '0;
                row_next  = last_row ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next  = col_reg + COL_W'(1);
                left_next = mid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WDIM_W'(RST_W);
            height_reg <= HDIM_W'(RST_H);
            col_reg    <= '0;
            row_reg    <= '0;
            left_reg   <= '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            left_reg   <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cur_reg <= first_col ? col1_reg : ram_q;
            if (first_col) begin
                col0_reg <= {mid, s_tdata};
            end
            if (col_reg == COL_W'(1)) begin
                col1_reg <= {mid, s_tdata};
            end
        end
    end

    assign job_valid     = accept && !second_row;
    assign job.up        = up;
    assign job.pix       = s_tdata;
    assign job.left      = left_reg;
    assign job.right     = right;
    assign job.interior  = !first_row && !first_col && !last_col;
    assign job.two_beats = !first_row && last_row;
    assign job.frame_end = last_col;

endmodule

/* sv/gam_fifo.sv */
module gam_fifo #(
    parameter int DEPTH = gam_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  gam_pkg::job_t push_job,
    output logic          in_ready,
    input  logic          pop,
    output logic          head_valid,
    output gam_pkg::job_t head
);

    import gam_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slots [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push) begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wptr_reg] <= push_job;
        end
    end

    assign in_ready   = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slots[rptr_reg];

endmodule

/* sv/gam_back.sv */
module gam_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      head_valid,
    input  gam_pkg::job_t             head,
    output logic                      pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [gam_pkg::PIX_W-1:0] m_tdata,
    output logic                      m_tlast,
    output logic                      m_tuser
);

    import gam_pkg::*;

    logic valid_reg, valid_next;
    logic second_reg, second_next;
    pix_t data_reg, data_next;
    logic last_reg, last_next;
    logic user_reg, user_next;

    pix_t         d_vert, d_horz;
    logic [PIX_W:0] sum;
    pix_t         mag;
    logic         load;

    assign d_vert = (head.up > head.pix) ? head.up - head.pix : head.pix - head.up;
    assign d_horz = (head.left > head.right) ? head.left - head.right
                                             : head.right - head.left;
    assign sum    = {1'b0, d_vert} + {1'b0, d_horz};
    assign mag    = !head.interior ? '0 : (sum[PIX_W] ? SAT_LIMIT : sum[PIX_W-1:0]);
    assign load   = !valid_reg || m_tready;

    always_comb begin
        valid_next  = valid_reg && !m_tready;
        second_next = second_reg;
        data_next   = data_reg;
        last_next   = last_reg;
        user_next   = user_reg;
        pop         = 1'b0;
        if (load && head_valid) begin
            valid_next = 1'b1;
            if (second_reg) begin
                // own border zero of the final row
                data_next   = '0;
                last_next   = 1'b1;
                user_next   = head.frame_end;
                second_next = 1'b0;
                pop         = 1'b1;
            end else if (head.two_beats) begin
                data_next   = mag;
                last_next   = 1'b0;
                user_next   = 1'b0;
                second_next = 1'b1;
            end else begin
                data_next = mag;
                last_next = 1'b1;
                user_next = 1'b0;
                pop       = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
        user_reg <= user_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

endmodule

/* sv/gradient_abs_magnitude_stream.sv */
// Gradient magnitude |up - down| + |left - right| of 8-bit grey pixels in raster order,
// saturated at 255 and zero on the frame border. A pixel beat is taken every cycle while the
// four-entry job queue has room; results leave through a registered output one beat per
// cycle while the sink is ready. Row 0 yields one zero per pixel, row 1 yields nothing, each
// later row yields the result for the row above, and the final row yields that result and
// then its own zero, so there the single output register gives two beats per pixel. An
// accepted pixel passes through its job queue slot and then the output register before its
// first result beat. Both line stores share one RAM read two columns ahead; they need no
// clearing after reset. A write of image_width or image_height restarts the frame.
module gradient_abs_magnitude_stream #(
    parameter int MAX_WIDTH  = gam_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gam_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [gam_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gam_pkg::DIM_W-1:0]       cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gam_pkg::PIX_W-1:0]       s_tdata,   // [7:0] pixel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gam_pkg::PIX_W-1:0]       m_tdata,   // [7:0] magnitude
    output logic                            m_tlast,
    output logic                            m_tuser    // [0] end_of_frame
);

    import gam_pkg::*;

    logic job_valid, queue_ready, head_valid, pop;
    job_t job, head;

    gam_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .queue_ready (queue_ready),
        .job_valid   (job_valid),
        .job         (job)
    );

    gam_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (job_valid),
        .push_job   (job),
        .in_ready   (queue_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    gam_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    a_eof_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("end of frame on a beat that is not last of its run");

    a_eof_is_border: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("end of frame beat carries a non-zero magnitude");

    a_pop_has_job: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("back end popped an empty queue");

endmodule
